>>> design/hng_pkg.sv
// ----------------------------------------------------------------------------
// hng_pkg
// Shared types and constants of the heightmap normal generator.
// ----------------------------------------------------------------------------
package hng_pkg;

  // default line buffer depth
  localparam int HNG_MAX_WIDTH = 1024;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_t;

  // register reset values
  localparam logic [10:0] MAP_WIDTH_RST  = 11'd256;
  localparam logic [15:0] MAP_HEIGHT_RST = 16'd256;

  // normalizer sizes: q = floor(num * 2^32 / den), then floor(sqrt(q))
  localparam int NUM_W      = 18;
  localparam int DEN_W      = 19;
  localparam int Q_W        = 33;
  localparam int DIV_STEPS  = 33;
  localparam int SQ_STEPS   = 17;
  localparam int ROOT_W     = 17;
  localparam int SQ_REM_W   = 20;
  localparam int LANE_LAT   = DIV_STEPS + SQ_STEPS + 1;
  localparam int BACK_LAT   = LANE_LAT + 1;

  // squared y term of the summed normal (510^2)
  localparam logic [NUM_W-1:0] SY_SQ = 18'd260100;

  // saturated 1.0 in Q1.15
  localparam logic signed [15:0] Q15_ONE = 16'sd32767;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;

  // one job handed from front to back
  typedef struct packed {
    logic signed [8:0] dx;
    logic signed [8:0] dz;
    logic [9:0]        col;
    logic [15:0]       row;
    logic              extra;
  } job_t;

endpackage

>>> design/hng_ram.sv
// ----------------------------------------------------------------------------
// hng_ram
// Generic RAM, one write port, two registered read ports with common enable.
// ----------------------------------------------------------------------------
module hng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> design/hng_front.sv
// ----------------------------------------------------------------------------
// hng_front
// Config registers, position counters and line buffers; builds one job per
// sample from row 1 on and pushes it to the queue.
// ----------------------------------------------------------------------------
module hng_front
  import hng_pkg::*;
#(
  parameter int MAX_WIDTH = HNG_MAX_WIDTH,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            height_sample,
  input  logic                  fifo_full,
  output logic                  push,
  output job_t                  job
);

  logic [10:0]   map_width;
  logic [15:0]   map_height;
  logic [CW-1:0] col_count;
  logic [15:0]   row_count;
  logic          refetch;
  logic [7:0]    left_prev;

  logic [CW-1:0] wlast;
  logic [15:0]   hlast;
  logic [CW-1:0] col_nxt;
  logic [CW-1:0] col_nxt2;
  logic          accept;
  logic          final_row;
  logic          interior;
  logic [15:0]   pair_cur;
  logic [15:0]   pair_ahead;
  logic [CW-1:0] raddr_a;
  logic [CW-1:0] raddr_b;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_WIDTH_RST;
      map_height <= MAP_HEIGHT_RST;
    end else if (cfg_write_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAP_WIDTH:  map_width  <= cfg_data[10:0];
        REG_MAP_HEIGHT: map_height <= cfg_data;
      endcase
    end
  end

  // clamped last column and last row
  always_comb begin
    if (int'(map_width) >= MAX_WIDTH) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else if (map_width < 11'd3) begin
      wlast = CW'(2);
    end else begin
      wlast = CW'(map_width - 11'd1);
    end
    hlast = (map_height < 16'd3) ? 16'd2 : map_height - 16'd1;
  end

  // next two column positions
  always_comb begin
    col_nxt  = (col_count >= wlast) ? '0 : col_count + CW'(1);
    col_nxt2 = (col_nxt >= wlast) ? '0 : col_nxt + CW'(1);
  end

  assign in_ready  = !refetch && !fifo_full;
  assign accept    = in_valid && in_ready;
  assign final_row = (row_count >= hlast);

  // line buffer entry: [15:8] previous row, [7:0] older row
  assign raddr_a = refetch ? col_count : col_nxt;
  assign raddr_b = refetch ? col_nxt : col_nxt2;

  hng_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .we      (accept),
    .waddr   (col_count),
    .wdata   ({height_sample, pair_cur[15:8]}),
    .re      (accept || refetch),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (pair_cur),
    .rdata_b (pair_ahead)
  );

  // prefetch control: re-read the window after reset or a config write
  always_ff @(posedge clk) begin
    if (rst) begin
      refetch <= 1'b1;
    end else if (cfg_write_en) begin
      refetch <= 1'b1;
    end else begin
      refetch <= 1'b0;
    end
  end

  // left neighbor is the previous-row value of the column accepted before
  always_ff @(posedge clk) begin
    if (accept) begin
      left_prev <= pair_cur[15:8];
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_count >= wlast) begin
        col_count <= '0;
        row_count <= final_row ? 16'd0 : row_count + 16'd1;
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // job for vertex one row behind the sample
  always_comb begin
    interior  = (col_count != '0) && (col_count < wlast) && (row_count >= 16'd2);
    push      = accept && (row_count != 16'd0);
    job.col   = 10'(col_count);
    job.row   = row_count - 16'd1;
    job.extra = final_row;
    if (interior) begin
      job.dx = $signed({1'b0, pair_ahead[15:8]}) - $signed({1'b0, left_prev});
      job.dz = $signed({1'b0, pair_cur[7:0]}) - $signed({1'b0, height_sample});
    end else begin
      job.dx = '0;
      job.dz = '0;
    end
  end

endmodule

>>> design/hng_fifo.sv
// ----------------------------------------------------------------------------
// hng_fifo
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module hng_fifo
  import hng_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  localparam int PW = $clog2(FIFO_DEPTH);

  job_t          entries [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(FIFO_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

>>> design/hng_lane.sv
// ----------------------------------------------------------------------------
// hng_lane
// One normal component: pipelined restoring divide num*2^32/den, pipelined
// integer square root, then round to nearest and saturate to Q1.15.
// ----------------------------------------------------------------------------
module hng_lane
  import hng_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [NUM_W-1:0]        num,
  input  logic [DEN_W-1:0]        den,
  input  logic                    neg,
  output logic signed [15:0]      comp
);

  logic [DEN_W-1:0]    d_rem [DIV_STEPS];
  logic [Q_W-1:0]      d_quo [DIV_STEPS];
  logic [DEN_W-1:0]    d_den [DIV_STEPS];
  logic                d_neg [DIV_STEPS];

  logic [Q_W:0]        s_q    [SQ_STEPS];
  logic [SQ_REM_W-1:0] s_rem  [SQ_STEPS];
  logic [ROOT_W-1:0]   s_root [SQ_STEPS];
  logic                s_neg  [SQ_STEPS];

  logic [ROOT_W:0]     root_inc;
  logic [ROOT_W-1:0]   rounded;
  logic [15:0]         mag;

  // divider, one quotient bit a stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DEN_W:0]   part;
    logic [DEN_W-1:0] dsrc;
    logic [Q_W-1:0]   qsrc;
    logic             nsrc;
    logic [DEN_W+1:0] diff;
    if (k == 0) begin : g_first
      assign part = (DEN_W+1)'(num);
      assign dsrc = den;
      assign qsrc = '0;
      assign nsrc = neg;
    end else begin : g_next
      assign part = {d_rem[k-1], 1'b0};
      assign dsrc = d_den[k-1];
      assign qsrc = d_quo[k-1];
      assign nsrc = d_neg[k-1];
    end
    assign diff = {1'b0, part} - {2'b00, dsrc};
    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[k] <= diff[DEN_W+1] ? part[DEN_W-1:0] : diff[DEN_W-1:0];
        d_quo[k] <= {qsrc[Q_W-2:0], ~diff[DEN_W+1]};
        d_den[k] <= dsrc;
        d_neg[k] <= nsrc;
      end
    end
  end

  // square root, one root bit a stage
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam int P = SQ_STEPS - 1 - j;
    logic [Q_W:0]          qsrc;
    logic [SQ_REM_W-1:0]   rsrc;
    logic [ROOT_W-1:0]     tsrc;
    logic                  nsrc;
    logic [SQ_REM_W+1:0]   cand;
    logic [SQ_REM_W+1:0]   trial;
    logic [SQ_REM_W+2:0]   diff;
    if (j == 0) begin : g_first
      assign qsrc = {1'b0, d_quo[DIV_STEPS-1]};
      assign rsrc = '0;
      assign tsrc = '0;
      assign nsrc = d_neg[DIV_STEPS-1];
    end else begin : g_next
      assign qsrc = s_q[j-1];
      assign rsrc = s_rem[j-1];
      assign tsrc = s_root[j-1];
      assign nsrc = s_neg[j-1];
    end
    assign cand  = {rsrc, qsrc[2*P+1 -: 2]};
    assign trial = (SQ_REM_W+2)'({tsrc, 2'b01});
    assign diff  = {1'b0, cand} - {1'b0, trial};
    always_ff @(posedge clk) begin
      if (en) begin
        s_q[j]    <= qsrc;
        s_rem[j]  <= diff[SQ_REM_W+2] ? cand[SQ_REM_W-1:0] : diff[SQ_REM_W-1:0];
        s_root[j] <= {tsrc[ROOT_W-2:0], ~diff[SQ_REM_W+2]};
        s_neg[j]  <= nsrc;
      end
    end
  end

  // round half up on the doubled root, saturate, apply sign
  always_comb begin
    root_inc = {1'b0, s_root[SQ_STEPS-1]} + (ROOT_W+1)'(1);
    rounded  = root_inc[ROOT_W:1];
    if (rounded[16] || rounded[15]) begin
      mag = 16'd32767;
    end else begin
      mag = {1'b0, rounded[14:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp <= s_neg[SQ_STEPS-1] ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

>>> design/hng_back.sv
// ----------------------------------------------------------------------------
// hng_back
// Takes jobs from the queue, squares the differences, runs three normalizer
// lanes and drives the result register, adding the final-row border result.
// ----------------------------------------------------------------------------
module hng_back
  import hng_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  job_t               job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [9:0]         vertex_col,
  output logic [15:0]        vertex_row,
  output logic               last_of_run
);

  logic             vld [BACK_LAT];
  job_t             tag [BACK_LAT];

  logic [7:0]       mag_x;
  logic [7:0]       mag_z;
  logic [15:0]      sq_x;
  logic [15:0]      sq_z;
  logic [NUM_W-1:0] num_x;
  logic [NUM_W-1:0] num_z;
  logic [DEN_W-1:0] den;
  logic             neg_x;
  logic             neg_z;

  logic signed [15:0] lane_x;
  logic signed [15:0] lane_y;
  logic signed [15:0] lane_z;

  logic        en;
  logic        slot_free;
  logic        second_pending;
  logic [9:0]  sec_col;
  logic [15:0] sec_row;
  job_t        tag_end;
  logic        vld_end;

  assign tag_end   = tag[BACK_LAT-1];
  assign vld_end   = vld[BACK_LAT-1];
  assign slot_free = !out_valid || out_ready;
  assign en        = !vld_end || (slot_free && !second_pending);
  assign pop       = en && job_valid;

  // squares of the differences
  always_comb begin
    mag_x = job.dx[8] ? 8'(-job.dx) : job.dx[7:0];
    mag_z = job.dz[8] ? 8'(-job.dz) : job.dz[7:0];
    sq_x  = mag_x * mag_x;
    sq_z  = mag_z * mag_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x <= NUM_W'(sq_x);
      num_z <= NUM_W'(sq_z);
      den   <= DEN_W'(sq_x) + DEN_W'(sq_z) + DEN_W'(SY_SQ);
      neg_x <= job.dx[8];
      neg_z <= job.dz[8];
    end
  end

  // valid and job tag travel beside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BACK_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= job_valid;
      for (int i = 1; i < BACK_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= job;
      for (int i = 1; i < BACK_LAT; i++) begin
        tag[i] <= tag[i-1];
      end
    end
  end

  hng_lane u_lane_x (
    .clk  (clk),
    .en   (en),
    .num  (num_x),
    .den  (den),
    .neg  (neg_x),
    .comp (lane_x)
  );

  hng_lane u_lane_y (
    .clk  (clk),
    .en   (en),
    .num  (SY_SQ),
    .den  (den),
    .neg  (1'b0),
    .comp (lane_y)
  );

  hng_lane u_lane_z (
    .clk  (clk),
    .en   (en),
    .num  (num_z),
    .den  (den),
    .neg  (neg_z),
    .comp (lane_z)
  );

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (slot_free) begin
      if (second_pending) begin
        out_valid      <= 1'b1;
        second_pending <= 1'b0;
      end else if (vld_end) begin
        out_valid      <= 1'b1;
        second_pending <= tag_end.extra;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload; the final-row vertex is always a flat border normal
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (second_pending) begin
        normal_x    <= '0;
        normal_y    <= Q15_ONE;
        normal_z    <= '0;
        vertex_col  <= sec_col;
        vertex_row  <= sec_row;
        last_of_run <= 1'b1;
      end else if (vld_end) begin
        normal_x    <= lane_x;
        normal_y    <= lane_y;
        normal_z    <= lane_z;
        vertex_col  <= tag_end.col;
        vertex_row  <= tag_end.row;
        last_of_run <= !tag_end.extra;
        sec_col     <= tag_end.col;
        sec_row     <= tag_end.row + 16'd1;
      end
    end
  end

endmodule

>>> design/heightmap_normal_generator_unit.sv
// ----------------------------------------------------------------------------
// heightmap_normal_generator_unit
// Streams heightmap bytes in row order and returns per-vertex unit normals
// in Q1.15, one row behind the input.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  in      | in  | in_valid / in_ready    | height_sample
//  out     | out | out_valid / out_ready  | normal_x/y/z, vertex_col, vertex_row,
//          |     |                        | last_of_run
//  cfg     | in  | cfg_write_en           | cfg_index, cfg_data
//
// One sample per cycle sustained while out_ready stays high; on the final row
// each sample gives two results, so the one-result-per-cycle output register
// sets the pace there. From sample to result a normal component passes 33
// divider and 17 square root stages, plus queue, squaring and output registers.
// in_ready drops for one cycle after reset and after each config write while
// the line buffer window is read again.
// A 4-beat job queue separates the front; the back pipeline freezes as a whole
// while its last stage holds a job that the output register cannot take yet.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_unit
  import hng_pkg::*;
#(
  parameter int MAX_WIDTH = HNG_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            height_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    normal_x,
  output logic signed [15:0]    normal_y,
  output logic signed [15:0]    normal_z,
  output logic [9:0]            vertex_col,
  output logic [15:0]           vertex_row,
  output logic                  last_of_run
);

  logic fifo_full;
  logic push;
  job_t push_job;
  logic pop;
  logic job_valid;
  job_t head_job;

  // front: counters and line buffers
  hng_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .height_sample (height_sample),
    .fifo_full     (fifo_full),
    .push          (push),
    .job           (push_job)
  );

  // job queue
  hng_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (fifo_full),
    .pop      (pop),
    .valid    (job_valid),
    .head     (head_job)
  );

  // back: normalizer and result register
  hng_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .vertex_col  (vertex_col),
    .vertex_row  (vertex_row),
    .last_of_run (last_of_run)
  );

endmodule

>>> design/hng_checker.sv
// ----------------------------------------------------------------------------
// hng_checker
// Port-level checks on the result stream of the normal generator.
// ----------------------------------------------------------------------------
module hng_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic [15:0]        vertex_row,
  input logic               last_of_run
);

  // a held beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y)
      && $stable(normal_z) && $stable(vertex_row))
    else $error("result beat changed while stalled");

  // nothing shown right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // y component always points up
  a_y_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_y > 16'sd0)
    else $error("normal_y not positive");

  // the final-row border beat follows at once, one row further, flat
  a_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid && last_of_run
      && normal_x == 16'sd0 && normal_z == 16'sd0 && normal_y == 16'sd32767
      && vertex_row == $past(vertex_row) + 16'd1)
    else $error("final-row border beat missing or wrong");

  // bottom row vertices are border vertices
  a_border: assert property (@(posedge clk) disable iff (rst)
    out_valid && vertex_row == 16'd0 |-> normal_x == 16'sd0 && normal_z == 16'sd0)
    else $error("bottom row normal not flat");

endmodule

bind heightmap_normal_generator_unit hng_checker u_hng_checker (.*);
